// ----- rtl/core/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_COLUMN_COUNT = 2'd1
    } t_cfg_index;

    localparam int CFG_DATA_W  = 12;
    localparam int ROW_W       = 12;
    localparam int WCOL_W      = 10;
    localparam int SUM_W       = 20;
    localparam int COLSUM_W    = 18;

    // Divide by nine: q = (x * DIV9_RECIP) >> DIV9_SHIFT, exact for x < 2**19
    localparam int                DIV9_X_W   = 19;
    localparam int                DIV9_R_W   = 21;
    localparam int                DIV9_P_W   = DIV9_X_W + DIV9_R_W;
    localparam int                DIV9_SHIFT = 24;
    localparam logic [DIV9_R_W-1:0] DIV9_RECIP = 21'd1864136;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef logic signed [15:0] t_sample;

    typedef struct packed {
        t_sample upper;
        t_sample middle;
    } t_line;

    typedef struct packed {
        t_sample upper;
        t_sample middle;
        t_sample current;
    } t_column;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ROW_W-1:0]        row;
        logic [WCOL_W-1:0]       col;
        logic                    last;
    } t_window;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        t_sample                 average;
        logic [ROW_W-1:0]        row;
        logic [WCOL_W-1:0]       col;
        logic                    last;
    } t_result;

endpackage

// ----- rtl/core/bfa_line_store.sv -----
// ----------------------------------------------------------------------------
// bfa_line_store
// Two-row line memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfa_line_store
    import bfa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line         i_wr_data
);

    t_line r_mem [DEPTH];
    t_line r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/bfa_column_cell.sv -----
// ----------------------------------------------------------------------------
// bfa_column_cell
// One window column: holds three samples and their sum, hands them on.
// ----------------------------------------------------------------------------
module bfa_column_cell
    import bfa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  t_column                    i_column,
    output t_column                    o_column,
    output logic signed [COLSUM_W-1:0] o_col_sum
);

    t_column                    r_column;
    logic signed [COLSUM_W-1:0] r_col_sum;
    logic signed [COLSUM_W-1:0] n_col_sum;

    assign n_col_sum = COLSUM_W'(i_column.upper) + COLSUM_W'(i_column.middle)
                     + COLSUM_W'(i_column.current);

    // advance on every transaction of the stream
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_column  <= i_column;
            r_col_sum <= n_col_sum;
        end
    end

    assign o_column  = r_column;
    assign o_col_sum = r_col_sum;

endmodule

// ----- rtl/core/bfa_div9.sv -----
// ----------------------------------------------------------------------------
// bfa_div9
// Three-stage signed divide by nine, round to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module bfa_div9
    import bfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_window i_win,
    output logic    o_valid,
    output t_result o_res
);

    logic                r_d1_valid;
    logic [DIV9_X_W-1:0] r_d1_x;
    logic                r_d1_neg;
    t_window             r_d1_win;
    logic                r_d2_valid;
    logic [DIV9_P_W-1:0] r_d2_prod;
    logic                r_d2_neg;
    t_window             r_d2_win;
    logic                r_d3_valid;
    t_result             r_d3_res;

    logic [SUM_W-1:0]    w_mag;
    logic [DIV9_X_W-1:0] w_x;
    logic [16:0]         w_q;
    logic [16:0]         w_q_neg;

    assign w_mag   = i_win.sum[SUM_W-1] ? (~i_win.sum + 1'b1) : i_win.sum;
    assign w_x     = w_mag[DIV9_X_W-1:0] + DIV9_X_W'(4);
    assign w_q     = r_d2_prod[DIV9_SHIFT +: 17];
    assign w_q_neg = ~w_q + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            r_d3_valid <= 1'b0;
        end else begin
            r_d1_valid <= i_valid;
            r_d2_valid <= r_d1_valid;
            r_d3_valid <= r_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_x    <= w_x;
        r_d1_neg  <= i_win.sum[SUM_W-1];
        r_d1_win  <= i_win;
        r_d2_prod <= DIV9_P_W'(r_d1_x) * DIV9_P_W'(DIV9_RECIP);
        r_d2_neg  <= r_d1_neg;
        r_d2_win  <= r_d1_win;
        r_d3_res.sum     <= r_d2_win.sum;
        r_d3_res.average <= r_d2_neg ? w_q_neg[15:0] : w_q[15:0];
        r_d3_res.row     <= r_d2_win.row;
        r_d3_res.col     <= r_d2_win.col;
        r_d3_res.last    <= r_d2_win.last;
    end

    assign o_valid = r_d3_valid;
    assign o_res   = r_d3_res;

endmodule

// ----- rtl/core/bfa_out_fifo.sv -----
// ----------------------------------------------------------------------------
// bfa_out_fifo
// Small result queue between the filter pipeline and the output stream.
// ----------------------------------------------------------------------------
module bfa_out_fifo
    import bfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/box_filter_3x3_average.sv -----
// ----------------------------------------------------------------------------
// box_filter_3x3_average
// 3x3 box filter over a raster stream of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while s_axis_tready is high and, for
// every complete 3x3 window (valid region only, no border padding), returns
// the window sum and the sum divided by nine, rounded to nearest with ties
// away from zero, together with the window's top row, left column and a
// tlast flag on the frame's last window. m_axis_tvalid for a result rises
// once it has passed stages 1 to 3, the divider and the output queue.
// Throughput is one transaction per clock while s_axis_tready is high, set by
// the line store, which reads a sample's column on acceptance and writes the
// line back in the following cycle. Up to eight results may be in flight or
// queued; while eight are held, s_axis_tready drops. Writing row_count or
// column_count restarts the frame at row zero, column zero; do it only while
// no results are outstanding. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module box_filter_3x3_average
    import bfa_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [15:0] sample
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [63:0]           m_axis_tdata,  // [19:0] window_sum,
                                                 // [35:20] window_average,
                                                 // [47:36] window_row,
                                                 // [57:48] window_column,
                                                 // [63:58] zero
    output logic                  m_axis_tlast   // frame_last
);

    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CCW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int XW  = (CW > WCOL_W) ? CW : WCOL_W;
    localparam int NCELL = 3;

    // ---------------- configuration and positions ----------------
    logic [ROW_W-1:0]  r_row_count;
    logic [10:0]       r_column_count;
    logic [ROW_W-1:0]  r_row;
    logic [CW-1:0]     r_col;
    logic [ROW_W-1:0]  n_row;
    logic [CW-1:0]     n_col;

    logic              w_cfg_hit;
    logic              w_accept;
    logic              w_produce;
    logic              w_row_end;
    logic              w_frame_end;
    logic [ROW_W-1:0]  w_rows_used;
    logic [CCW-1:0]    w_cols_cfg;
    logic [CCW-1:0]    w_cols_used;
    logic [CCW-1:0]    w_col_inc;
    logic [ROW_W:0]    w_row_inc;
    logic [XW-1:0]     w_wcol;

    // pending results: in the pipeline or in the output queue
    logic [FIFO_CNT_W-1:0] r_pending;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_pending != FIFO_CNT_W'(FIFO_DEPTH));

    // a count of zero acts as one; clamp columns to the line store depth
    assign w_rows_used = (r_row_count == '0) ? ROW_W'(1) : r_row_count;
    assign w_cols_cfg  = CCW'(r_column_count);
    always_comb begin
        if (w_cols_cfg == '0) begin
            w_cols_used = CCW'(1);
        end else if (w_cols_cfg > CCW'(MAX_COLUMNS)) begin
            w_cols_used = CCW'(MAX_COLUMNS);
        end else begin
            w_cols_used = w_cols_cfg;
        end
    end

    assign w_col_inc   = CCW'(r_col) + CCW'(1);
    assign w_row_inc   = {1'b0, r_row} + (ROW_W + 1)'(1);
    assign w_row_end   = (w_col_inc >= w_cols_used);
    assign w_frame_end = (w_row_inc >= {1'b0, w_rows_used});
    assign w_produce   = (r_row >= ROW_W'(2)) && (r_col >= CW'(2));
    assign w_wcol      = XW'(r_col) - XW'(2);

    // register decode: a known index restarts the frame
    always_comb begin
        w_cfg_hit = 1'b0;
        unique case (i_cfg_index)
            CFG_ROW_COUNT:    w_cfg_hit = i_cfg_we;
            CFG_COLUMN_COUNT: w_cfg_hit = i_cfg_we;
            default:          w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROW_W'(3);
            r_column_count <= 11'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    // advance the raster position on each input transaction; a config write resets it
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_cfg_hit) begin
            n_row = '0;
            n_col = '0;
        end else if (w_accept) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = w_frame_end ? '0 : w_row_inc[ROW_W-1:0];
            end else begin
                n_col = w_col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic              r_s1_valid;
    logic              r_s1_res;
    t_sample           r_s1_cur;
    logic [CW-1:0]     r_s1_addr;
    logic [ROW_W-1:0]  r_s1_row;
    logic [WCOL_W-1:0] r_s1_col;
    logic              r_s1_last;
    t_line             w_rd_line;
    t_line             w_wr_line;
    t_column           w_new_column;

    bfa_line_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_line),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_line)
    );

    // push each row up one line
    assign w_wr_line.upper  = w_rd_line.middle;
    assign w_wr_line.middle = r_s1_cur;

    assign w_new_column.upper   = w_rd_line.upper;
    assign w_new_column.middle  = w_rd_line.middle;
    assign w_new_column.current = r_s1_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_res   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_res   <= w_accept && w_produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cur  <= s_axis_tdata;
            r_s1_addr <= r_col;
            r_s1_row  <= r_row - ROW_W'(2);
            r_s1_col  <= w_wcol[WCOL_W-1:0];
            r_s1_last <= w_frame_end && w_row_end;
        end
    end

    // ---------------- stage 2: column cells ----------------
    // cell 2 takes the new column, older columns move toward cell 0
    t_column                    w_cell_in  [NCELL];
    t_column                    w_cell_out [NCELL];
    logic signed [COLSUM_W-1:0] w_cell_sum [NCELL];

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k == NCELL - 1) begin : g_head
            assign w_cell_in[k] = w_new_column;
        end else begin : g_link
            assign w_cell_in[k] = w_cell_out[k+1];
        end
        bfa_column_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (r_s1_valid),
            .i_column  (w_cell_in[k]),
            .o_column  (w_cell_out[k]),
            .o_col_sum (w_cell_sum[k])
        );
    end

    logic              r_s2_res;
    logic [ROW_W-1:0]  r_s2_row;
    logic [WCOL_W-1:0] r_s2_col;
    logic              r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_res <= 1'b0;
        end else begin
            r_s2_res <= r_s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_row  <= r_s1_row;
        r_s2_col  <= r_s1_col;
        r_s2_last <= r_s1_last;
    end

    // ---------------- stage 3: window sum ----------------
    logic    r_s3_valid;
    t_window r_s3_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_win.sum  <= SUM_W'(w_cell_sum[0]) + SUM_W'(w_cell_sum[1])
                       + SUM_W'(w_cell_sum[2]);
        r_s3_win.row  <= r_s2_row;
        r_s3_win.col  <= r_s2_col;
        r_s3_win.last <= r_s2_last;
    end

    // ---------------- divide and queue ----------------
    logic    w_div_valid;
    t_result w_div_res;
    t_result w_out;

    bfa_div9 u_div9 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_win   (r_s3_win),
        .o_valid (w_div_valid),
        .o_res   (w_div_res)
    );

    bfa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_div_valid),
        .i_data  (w_div_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out.col, w_out.row, w_out.average, w_out.sum};
    assign m_axis_tlast = w_out.last;

    // hold a credit from the accepting transaction until the result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending
                       + FIFO_CNT_W'(w_accept && w_produce)
                       - FIFO_CNT_W'(m_axis_tvalid && m_axis_tready);
        end
    end

    // ---------------- assertions ----------------
    a_pending_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("pending result count exceeds queue depth");

    a_out_has_credit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != '0))
        else $error("output valid without a pending result");

    a_result_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_produce) |=> (r_pending != '0) && r_s1_res)
        else $error("window transaction lost before stage 1");

    a_div_has_credit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid |-> (r_pending != '0))
        else $error("divider result without a pending credit");

endmodule
